// ===== rtl/core/fmdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmdq_pkg
// Command and status codes and fixed field widths for the dual-order queue.
// ----------------------------------------------------------------------------
package fmdq_pkg;

   localparam int NUM_BITS    = 32;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_ARRIVE       = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SERVE_OLDEST = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SERVE_HIGH   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_SERVED   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_ACCEPTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_REFUSED  = 2'd3;

endpackage

// ===== rtl/core/fifo_and_max_dual_dequeue.sv =====
`timescale 1ns / 1ps
// Arrival and empty/unused commands: result registered in the cycle after accept, one item per cycle while not stalled.
// Serve oldest: result registered in the cycle after accept, then busy (S_COMPACT_RD, S_COMPACT_CHK)
//   to skip served entries, stopping when the queue runs empty.
// Serve highest: scan of the waiting window through the slot store, one slot per cycle, then S_PICK,
//   plus compaction if the oldest was taken.
// Reset clears control state only; the slot store is not cleared (entries are written on arrival).
// ----------------------------------------------------------------------------
// fifo_and_max_dual_dequeue
// Waiting queue with oldest-first and highest-value-first removal, using a
// slot store and a single read/compare path stepped by a small sequencer.
// ----------------------------------------------------------------------------
module fifo_and_max_dual_dequeue #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fmdq_pkg::CMD_BITS-1:0]    req_cmd,
   input  logic [VALUE_BITS-1:0]            req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fmdq_pkg::NUM_BITS-1:0]    rsp_entry_number,
   output logic [fmdq_pkg::STATUS_BITS-1:0] rsp_status
);
   import fmdq_pkg::*;

   localparam int SLOT_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(CAPACITY - 1);
   localparam logic [CNT_BITS-1:0]  FULL_COUNT = CNT_BITS'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_COMPACT_RD,
      S_COMPACT_CHK
   } state_type;

   state_type               state_ff, state_in;
   logic [NUM_BITS-1:0]     oldest_ff, oldest_in;
   logic [NUM_BITS-1:0]     next_ff, next_in;
   logic [SLOT_BITS-1:0]    oldest_slot_ff, oldest_slot_in;
   logic [SLOT_BITS-1:0]    next_slot_ff, next_slot_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [SLOT_BITS-1:0]    scan_slot_ff, scan_slot_in;
   logic [CNT_BITS-1:0]     scan_off_ff, scan_off_in;
   logic                    pend_ff, pend_in;
   logic [SLOT_BITS-1:0]    pend_off_ff, pend_off_in;
   logic [SLOT_BITS-1:0]    pend_slot_ff, pend_slot_in;
   logic                    best_found_ff, best_found_in;
   logic [VALUE_BITS-1:0]   best_val_ff, best_val_in;
   logic [SLOT_BITS-1:0]    best_off_ff, best_off_in;
   logic [SLOT_BITS-1:0]    best_slot_ff, best_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUM_BITS-1:0]     rsp_num_ff, rsp_num_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   logic [VALUE_BITS-1:0]   value_mem [CAPACITY];
   logic                    served_mem [CAPACITY];
   logic [VALUE_BITS-1:0]   value_rd_ff;
   logic                    served_rd_ff;

   logic                    accept;
   logic                    rsp_free;
   logic                    issue;
   logic [SLOT_BITS-1:0]    rd_addr;
   logic                    wr_val_en;
   logic                    wr_srv_en;
   logic [SLOT_BITS-1:0]    wr_addr;
   logic                    wr_srv_bit;

   function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SLOT_BITS'(1);
   endfunction

   assign req_stall        = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept           = req_valid && !req_stall;
   assign rsp_free         = !rsp_valid_ff || !rsp_stall;
   assign issue            = (scan_off_ff != count_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_number = rsp_num_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      oldest_in      = oldest_ff;
      next_in        = next_ff;
      oldest_slot_in = oldest_slot_ff;
      next_slot_in   = next_slot_ff;
      count_in       = count_ff;
      scan_slot_in   = scan_slot_ff;
      scan_off_in    = scan_off_ff;
      pend_in        = 1'b0;
      pend_off_in    = pend_off_ff;
      pend_slot_in   = pend_slot_ff;
      best_found_in  = best_found_ff;
      best_val_in    = best_val_ff;
      best_off_in    = best_off_ff;
      best_slot_in   = best_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_num_in     = rsp_num_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = oldest_slot_ff;
      wr_val_en      = 1'b0;
      wr_srv_en      = 1'b0;
      wr_addr        = next_slot_ff;
      wr_srv_bit     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = '0;
               rsp_status_in = ST_EMPTY;
               case (req_cmd)
                  CMD_ARRIVE: begin
                     if (next_ff == '0 || count_ff == FULL_COUNT) begin
                        rsp_status_in = ST_REFUSED;
                     end else begin
                        wr_val_en     = 1'b1;
                        wr_srv_en     = 1'b1;
                        next_in       = next_ff + NUM_BITS'(1);
                        next_slot_in  = slot_inc(next_slot_ff);
                        count_in      = count_ff + CNT_BITS'(1);
                        rsp_num_in    = next_ff;
                        rsp_status_in = ST_ACCEPTED;
                     end
                  end
                  CMD_SERVE_OLDEST: begin
                     if (count_ff != '0) begin
                        rsp_num_in     = oldest_ff;
                        rsp_status_in  = ST_SERVED;
                        oldest_in      = oldest_ff + NUM_BITS'(1);
                        oldest_slot_in = slot_inc(oldest_slot_ff);
                        count_in       = count_ff - CNT_BITS'(1);
                        state_in       = S_COMPACT_RD;
                     end
                  end
                  CMD_SERVE_HIGH: begin
                     if (count_ff != '0) begin
                        rsp_valid_in  = rsp_valid_ff && rsp_stall;
                        rsp_num_in    = rsp_num_ff;
                        rsp_status_in = rsp_status_ff;
                        scan_slot_in  = oldest_slot_ff;
                        scan_off_in   = '0;
                        best_found_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr = scan_slot_ff;
            if (issue) begin
               pend_in      = 1'b1;
               pend_off_in  = scan_off_ff[SLOT_BITS-1:0];
               pend_slot_in = scan_slot_ff;
               scan_off_in  = scan_off_ff + CNT_BITS'(1);
               scan_slot_in = slot_inc(scan_slot_ff);
            end
            // strict compare keeps the earliest arrival on equal values
            if (pend_ff && !served_rd_ff &&
                (!best_found_ff || value_rd_ff > best_val_ff)) begin
               best_found_in = 1'b1;
               best_val_in   = value_rd_ff;
               best_off_in   = pend_off_ff;
               best_slot_in  = pend_slot_ff;
            end
            if (!issue && !pend_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = oldest_ff + NUM_BITS'(best_off_ff);
               rsp_status_in = ST_SERVED;
               if (best_off_ff == '0) begin
                  oldest_in      = oldest_ff + NUM_BITS'(1);
                  oldest_slot_in = slot_inc(oldest_slot_ff);
                  count_in       = count_ff - CNT_BITS'(1);
                  state_in       = S_COMPACT_RD;
               end else begin
                  wr_srv_en  = 1'b1;
                  wr_addr    = best_slot_ff;
                  wr_srv_bit = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_COMPACT_RD: begin
            state_in = (count_ff == '0) ? S_IDLE : S_COMPACT_CHK;
         end
         S_COMPACT_CHK: begin
            if (served_rd_ff) begin
               oldest_in      = oldest_ff + NUM_BITS'(1);
               oldest_slot_in = slot_inc(oldest_slot_ff);
               count_in       = count_ff - CNT_BITS'(1);
               state_in       = S_COMPACT_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_val_en) begin
         value_mem[wr_addr] <= req_value;
      end
      if (wr_srv_en) begin
         served_mem[wr_addr] <= wr_srv_bit;
      end
      value_rd_ff  <= value_mem[rd_addr];
      served_rd_ff <= served_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      scan_slot_ff  <= scan_slot_in;
      pend_off_ff   <= pend_off_in;
      pend_slot_ff  <= pend_slot_in;
      best_val_ff   <= best_val_in;
      best_off_ff   <= best_off_in;
      best_slot_ff  <= best_slot_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         oldest_ff      <= NUM_BITS'(1);
         next_ff        <= NUM_BITS'(1);
         oldest_slot_ff <= '0;
         next_slot_ff   <= '0;
         count_ff       <= '0;
         scan_off_ff    <= '0;
         pend_ff        <= 1'b0;
         best_found_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         oldest_ff      <= oldest_in;
         next_ff        <= next_in;
         oldest_slot_ff <= oldest_slot_in;
         next_slot_ff   <= next_slot_in;
         count_ff       <= count_in;
         scan_off_ff    <= scan_off_in;
         pend_ff        <= pend_in;
         best_found_ff  <= best_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule
